// File: sv/multilinear_unit_cube_interp_unit_defines.svh
// Assertion macros for the multilinear unit cube interpolator.
// Included by the top level; needs a clock named clock and a reset named reset in scope.
`ifndef MULTILINEAR_UNIT_CUBE_INTERP_UNIT_DEFINES_SVH
`define MULTILINEAR_UNIT_CUBE_INTERP_UNIT_DEFINES_SVH
`ifndef SYNTH
// Condition that must hold at every clock edge outside reset.
`define MUCI_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// Overlapping implication checked at every clock edge outside reset.
`define MUCI_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define MUCI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MUCI_ASSERT(label, expr, msg)
`define MUCI_ASSERT_IMP(label, ante, cons, msg)
`define MUCI_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: sv/muci_pkg.sv
// Shared widths, constants and the pipeline control bundle of the interpolator.
// No dependencies; used by the lane, the merge stage and the top level.
`timescale 1ns / 1ps

package muci_pkg;

   localparam int COORD_W    = 17;
   localparam int VALUE_W    = 16;
   localparam int FRAC_W     = 16;
   localparam int MAX_AXES   = 3;
   localparam int PROD_W     = 32;
   localparam int PAIR_W     = PROD_W + 1;
   localparam int SUM_W      = PROD_W + 4;
   localparam int NUM_STAGES = 6;

   // Lane stages 0..3, merge stages 4..5.
   localparam int ST_MERGE_PAIR = 4;
   localparam int ST_MERGE_OUT  = 5;

   localparam logic [COORD_W-1:0] ONE_Q16 = COORD_W'(1 << FRAC_W);
   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   // Per-stage load enables and the decoded dimension setting.
   typedef struct packed {
      logic [NUM_STAGES-1:0] adv;
      logic [1:0]            eff_dims;
      logic                  use_axis1;
      logic                  use_axis2;
   } ctrl_type;

endpackage

// File: sv/multilinear_unit_cube_interp_unit.sv
// d-linear interpolation (d = 1..3) of signed 16-bit corner samples at a Q1.16 point in the
// unit cube. Throughput is one word per cycle unless rsp_ready stalls the output. There are four
// stages in each corner lane (capture, axis 1 weight multiply, axis 2 weight multiply, sample
// multiply) and two in the merge (pair sums, then total, round and saturate). Each stage
// holds its word only while the stage after it is full and stalled, so a result waiting
// on rsp_ready does not stop new words from entering until the pipeline is full. Coordinates
// above 1.0 are clamped to 1.0; dims_in_use of 0 acts as 1 and values above MAX_DIMS act as
// MAX_DIMS. Write dims_in_use only while no word is in flight.
// Depends on muci_pkg, muci_lane, muci_merge and the assertion macro header.
`timescale 1ns / 1ps
`include "multilinear_unit_cube_interp_unit_defines.svh"

module multilinear_unit_cube_interp_unit
   import muci_pkg::*;
#(
   parameter int MAX_DIMS = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_dims_in_use,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COORD_W-1:0] req_coord_0,
   input  logic [COORD_W-1:0] req_coord_1,
   input  logic [COORD_W-1:0] req_coord_2,
   input  logic [VALUE_W-1:0] req_value_0,
   input  logic [VALUE_W-1:0] req_value_1,
   input  logic [VALUE_W-1:0] req_value_2,
   input  logic [VALUE_W-1:0] req_value_3,
   input  logic [VALUE_W-1:0] req_value_4,
   input  logic [VALUE_W-1:0] req_value_5,
   input  logic [VALUE_W-1:0] req_value_6,
   input  logic [VALUE_W-1:0] req_value_7,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VALUE_W-1:0] rsp_interpolated
);

   localparam int NUM_LANES = 1 << MAX_DIMS;

   logic [1:0]                       dims_ff;
   logic [1:0]                       eff_dims;
   logic [NUM_STAGES-1:0]            valid_ff, valid_in, adv;
   ctrl_type                         ctrl;
   logic [MAX_AXES-1:0][COORD_W-1:0] coord_raw, coord_clamped;
   logic [7:0][VALUE_W-1:0]          values;
   logic [NUM_LANES-1:0][PROD_W-1:0] products;

   // Dimension register.
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= 2'd3;
      end else if (csr_wr_en) begin
         dims_ff <= csr_dims_in_use;
      end
   end

   // Effective dimension count, limited to one through MAX_DIMS.
   always_comb begin
      if (dims_ff == 2'd0) begin
         eff_dims = 2'd1;
      end else if (dims_ff > 2'(MAX_DIMS)) begin
         eff_dims = 2'(MAX_DIMS);
      end else begin
         eff_dims = dims_ff;
      end
   end

   // A stage may load when it is empty or the stage after it is moving.
   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (adv[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   assign ctrl.adv       = adv;
   assign ctrl.eff_dims  = eff_dims;
   assign ctrl.use_axis1 = (eff_dims >= 2'd2);
   assign ctrl.use_axis2 = (eff_dims >= 2'd3);

   // Clamp coordinates to 1.0.
   assign coord_raw = {req_coord_2, req_coord_1, req_coord_0};
   always_comb begin
      for (int a = 0; a < MAX_AXES; a++) begin
         coord_clamped[a] = (coord_raw[a] > ONE_Q16) ? ONE_Q16 : coord_raw[a];
      end
   end

   assign values = {req_value_7, req_value_6, req_value_5, req_value_4,
                    req_value_3, req_value_2, req_value_1, req_value_0};

   // One lane per corner.
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      muci_lane #(
         .LANE(l)
      ) u_lane (
         .clock  (clock),
         .ctrl   (ctrl),
         .coord  (coord_clamped),
         .sample (values[l]),
         .product(products[l])
      );
   end

   muci_merge #(
      .NUM_LANES(NUM_LANES)
   ) u_merge (
      .clock       (clock),
      .ctrl        (ctrl),
      .product     (products),
      .interpolated(rsp_interpolated)
   );

   // An accepted word must occupy the first stage on the next cycle.
   `MUCI_ASSERT_NEXT(a_accept_lands, req_valid && req_ready, valid_ff[0], "accepted word lost")
   // Without output backpressure nothing in the pipeline may stall.
   `MUCI_ASSERT_IMP(a_no_stall, rsp_ready, req_ready, "input stalled with output ready")
   // Input is refused only when every stage is full.
   `MUCI_ASSERT_IMP(a_full_on_stall, !req_ready, &valid_ff, "input stalled with a bubble")

endmodule

// File: sv/muci_lane.sv
// One corner lane: builds the corner weight axis by axis and scales the corner sample.
// Depends on muci_pkg; instantiated once per corner by the top level.
`timescale 1ns / 1ps

module muci_lane
   import muci_pkg::*;
#(
   parameter int LANE = 0
) (
   input  logic                               clock,
   input  ctrl_type                           ctrl,
   input  logic [MAX_AXES-1:0][COORD_W-1:0]   coord,
   input  logic [VALUE_W-1:0]                 sample,
   output logic [PROD_W-1:0]                  product
);

   localparam logic BIT0 = 1'((LANE % 2) == 1);
   localparam logic BIT1 = 1'(((LANE / 2) % 2) == 1);
   localparam logic BIT2 = 1'(((LANE / 4) % 2) == 1);

   logic [COORD_W-1:0] f0, f1, f2;
   logic [COORD_W-1:0] w0_ff, f1_ff, f2_ff;
   logic [VALUE_W-1:0] smp0_ff;
   logic [COORD_W-1:0] w1_ff, f2b_ff, w1_in;
   logic [VALUE_W-1:0] smp1_ff;
   logic [COORD_W-1:0] w2_ff, w2_in;
   logic [VALUE_W-1:0] smp2_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [2*COORD_W-1:0] mul1, mul2;
   logic [3:0]         corners;

   // Each axis factor is x when this corner's index bit is set, else one minus x.
   assign f0 = BIT0 ? coord[0] : ONE_Q16 - coord[0];
   assign f1 = BIT1 ? coord[1] : ONE_Q16 - coord[1];
   assign f2 = BIT2 ? coord[2] : ONE_Q16 - coord[2];

   // Stage 0: capture the word; the axis 0 factor is the starting weight.
   always_ff @(posedge clock) begin
      if (ctrl.adv[0]) begin
         w0_ff   <= f0;
         f1_ff   <= f1;
         f2_ff   <= f2;
         smp0_ff <= sample;
      end
   end

   // Stage 1: fold in axis 1, truncating to 16 fractional bits.
   assign mul1  = {{COORD_W{1'b0}}, w0_ff} * {{COORD_W{1'b0}}, f1_ff};
   assign w1_in = ctrl.use_axis1 ? mul1[FRAC_W +: COORD_W] : w0_ff;

   always_ff @(posedge clock) begin
      if (ctrl.adv[1]) begin
         w1_ff   <= w1_in;
         f2b_ff  <= f2_ff;
         smp1_ff <= smp0_ff;
      end
   end

   // Stage 2: fold in axis 2.
   assign mul2  = {{COORD_W{1'b0}}, w1_ff} * {{COORD_W{1'b0}}, f2b_ff};
   assign w2_in = ctrl.use_axis2 ? mul2[FRAC_W +: COORD_W] : w1_ff;

   always_ff @(posedge clock) begin
      if (ctrl.adv[2]) begin
         w2_ff   <= w2_in;
         smp2_ff <= smp1_ff;
      end
   end

   // Stage 3: scale the sample; corners beyond the configured count give zero.
   assign corners = 4'(1) << ctrl.eff_dims;
   assign prod_in = (4'(LANE) < corners)
      ? PROD_W'($signed({{(PROD_W-VALUE_W){smp2_ff[VALUE_W-1]}}, smp2_ff})
         * $signed({{(PROD_W-COORD_W){1'b0}}, w2_ff}))
      : '0;

   always_ff @(posedge clock) begin
      if (ctrl.adv[3]) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

// File: sv/muci_merge.sv
// Merge stage: adds the lane products, rounds to nearest and saturates to 16 bits.
// Depends on muci_pkg; fed by the muci_lane instances in the top level.
`timescale 1ns / 1ps

module muci_merge
   import muci_pkg::*;
#(
   parameter int NUM_LANES = 8
) (
   input  logic                              clock,
   input  ctrl_type                          ctrl,
   input  logic [NUM_LANES-1:0][PROD_W-1:0]  product,
   output logic [VALUE_W-1:0]                interpolated
);

   localparam int NUM_PAIRS = NUM_LANES / 2;
   localparam int Q_W       = SUM_W - FRAC_W;

   logic [NUM_PAIRS-1:0][PAIR_W-1:0] pair_ff, pair_in;
   logic signed [SUM_W-1:0]          sum, rounded;
   logic signed [Q_W-1:0]            q;
   logic [VALUE_W-1:0]               result_ff, result_in;

   // First level of the adder tree: neighboring lanes in pairs.
   always_comb begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
         pair_in[p] = {product[2*p][PROD_W-1], product[2*p]}
                    + {product[2*p+1][PROD_W-1], product[2*p+1]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[ST_MERGE_PAIR]) begin
         pair_ff <= pair_in;
      end
   end

   // Second level: total, round half up, then clamp to the sample range.
   always_comb begin
      sum = '0;
      for (int p = 0; p < NUM_PAIRS; p++) begin
         sum = sum + $signed({{(SUM_W-PAIR_W){pair_ff[p][PAIR_W-1]}}, pair_ff[p]});
      end
      rounded = sum + $signed(SUM_W'(1 << (FRAC_W - 1)));
      q       = rounded[SUM_W-1:FRAC_W];
      if (q > $signed({{(Q_W-VALUE_W){1'b0}}, VALUE_MAX})) begin
         result_in = VALUE_MAX;
      end else if (q < $signed({{(Q_W-VALUE_W){1'b1}}, VALUE_MIN})) begin
         result_in = VALUE_MIN;
      end else begin
         result_in = q[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[ST_MERGE_OUT]) begin
         result_ff <= result_in;
      end
   end

   assign interpolated = result_ff;

endmodule
